/* hdl/sid_pkg.sv */
// ----------------------------------------------------------------------------
// sid_pkg: shared types and constants for the segment intersection block
// Coefficient and box widths, the divider geometry and the sideband record
// that travels along the pipeline next to the arithmetic.
// ----------------------------------------------------------------------------
package sid_pkg;

  localparam int CoefW  = 16;
  localparam int FracB  = 8;
  localparam int ProdW  = 2 * CoefW;
  localparam int SumW   = ProdW + 1;
  localparam int MagW   = SumW;
  localparam int NumW   = MagW + FracB;
  localparam int QBits  = CoefW + 1;
  localparam int QW     = QBits + 1;
  localparam int RemW   = (NumW > MagW + QBits) ? NumW : MagW + QBits;
  localparam int BoxW   = 4 * CoefW;

  // Box lanes, packed from the low bits.
  localparam int LaneXMin = 0;
  localparam int LaneXMax = 1;
  localparam int LaneYMin = 2;
  localparam int LaneYMax = 3;

  typedef logic signed [CoefW-1:0] coef_t;
  typedef logic [BoxW-1:0]         box_t;

  typedef struct packed {
    box_t p;
    box_t q;
    logic det_zero;
    logic nx_zero;
  } side_t;

  function automatic coef_t box_lane(input box_t b, input int j);
    return coef_t'(b[j*CoefW +: CoefW]);
  endfunction

endpackage

/* hdl/sid_cross.sv */
// ----------------------------------------------------------------------------
// sid_cross: cross products and Cramer determinants
// Stage one forms the six coefficient products, stage two the determinant,
// both numerators and the zero flags used for the degenerate cases.
// ----------------------------------------------------------------------------
module sid_cross import sid_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   valid_i,
  output logic                   ready_o,
  input  coef_t                  a1_i,
  input  coef_t                  b1_i,
  input  coef_t                  c1_i,
  input  coef_t                  a2_i,
  input  coef_t                  b2_i,
  input  coef_t                  c2_i,
  input  box_t                   p_i,
  input  box_t                   q_i,
  output logic                   valid_o,
  input  logic                   ready_i,
  output logic signed [SumW-1:0] det_o,
  output logic signed [SumW-1:0] nx_o,
  output logic signed [SumW-1:0] ny_o,
  output side_t                  side_o
);

  logic signed [ProdW-1:0] prod_q [6];
  logic signed [ProdW-1:0] prod_d [6];
  box_t  p_q, q_q;
  logic  v1_q, v2_q;
  logic  rdy1, rdy2;
  logic signed [SumW-1:0] det_q, nx_q, ny_q;
  side_t side_q, side_d;

  assign rdy2    = !v2_q || ready_i;
  assign rdy1    = !v1_q || rdy2;
  assign ready_o = rdy1;

  always_comb begin
    prod_d[0] = a1_i * b2_i;
    prod_d[1] = a2_i * b1_i;
    prod_d[2] = b1_i * c2_i;
    prod_d[3] = b2_i * c1_i;
    prod_d[4] = a2_i * c1_i;
    prod_d[5] = a1_i * c2_i;
  end

  always_comb begin
    side_d.p        = p_q;
    side_d.q        = q_q;
    side_d.det_zero = (prod_q[0] == prod_q[1]);
    side_d.nx_zero  = (prod_q[2] == prod_q[3]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= valid_i;
      if (rdy2) v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      prod_q <= prod_d;
      p_q    <= p_i;
      q_q    <= q_i;
    end
    if (rdy2) begin
      det_q  <= SumW'(prod_q[0]) - SumW'(prod_q[1]);
      nx_q   <= SumW'(prod_q[2]) - SumW'(prod_q[3]);
      ny_q   <= SumW'(prod_q[4]) - SumW'(prod_q[5]);
      side_q <= side_d;
    end
  end

  assign valid_o = v2_q;
  assign det_o   = det_q;
  assign nx_o    = nx_q;
  assign ny_o    = ny_q;
  assign side_o  = side_q;

endmodule

/* hdl/sid_div.sv */
// ----------------------------------------------------------------------------
// sid_div: pipelined restoring divider for both coordinates
// A front stage takes magnitudes and detects quotients too large for the
// result range; then one quotient bit per stage is resolved for x and y.
// ----------------------------------------------------------------------------
module sid_div import sid_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   valid_i,
  output logic                   ready_o,
  input  logic signed [SumW-1:0] det_i,
  input  logic signed [SumW-1:0] nx_i,
  input  logic signed [SumW-1:0] ny_i,
  input  side_t                  side_i,
  output logic                   valid_o,
  input  logic                   ready_i,
  output logic [QBits-1:0]       mag_x_o,
  output logic [QBits-1:0]       mag_y_o,
  output logic                   neg_x_o,
  output logic                   neg_y_o,
  output side_t                  side_o
);

  typedef struct packed {
    logic [RemW-1:0]  rem_x;
    logic [RemW-1:0]  rem_y;
    logic [QBits-1:0] quo_x;
    logic [QBits-1:0] quo_y;
    logic [MagW-1:0]  dm;
    logic             neg_x;
    logic             neg_y;
    logic             ov_x;
    logic             ov_y;
    side_t            side;
  } div_t;

  div_t             st_q [QBits+1];
  div_t             st_d [QBits+1];
  logic [QBits:0]   v_q;
  logic [QBits+1:0] rdy;

  assign rdy[QBits+1] = ready_i;

  // Front stage: magnitudes, signs and range check.
  always_comb begin
    logic [MagW-1:0] dm, mx, my;
    logic [RemW-1:0] dsh;
    dm  = det_i[SumW-1] ? MagW'(-det_i) : MagW'(det_i);
    mx  = nx_i[SumW-1]  ? MagW'(-nx_i)  : MagW'(nx_i);
    my  = ny_i[SumW-1]  ? MagW'(-ny_i)  : MagW'(ny_i);
    dsh = RemW'(dm) << QBits;
    st_d[0].rem_x = RemW'(mx) << FracB;
    st_d[0].rem_y = RemW'(my) << FracB;
    st_d[0].quo_x = '0;
    st_d[0].quo_y = '0;
    st_d[0].dm    = dm;
    st_d[0].neg_x = nx_i[SumW-1] ^ det_i[SumW-1];
    st_d[0].neg_y = ny_i[SumW-1] ^ det_i[SumW-1];
    st_d[0].ov_x  = (RemW'(mx) << FracB) >= dsh;
    st_d[0].ov_y  = (RemW'(my) << FracB) >= dsh;
    st_d[0].side  = side_i;
  end

  for (genvar k = 0; k <= QBits; k++) begin : g_stage
    if (k > 0) begin : g_iter
      localparam int Sh = QBits - k;
      always_comb begin
        logic [RemW-1:0] t;
        t        = RemW'(st_q[k-1].dm) << Sh;
        st_d[k]  = st_q[k-1];
        if (st_q[k-1].rem_x >= t) begin
          st_d[k].rem_x     = st_q[k-1].rem_x - t;
          st_d[k].quo_x[Sh] = 1'b1;
        end
        if (st_q[k-1].rem_y >= t) begin
          st_d[k].rem_y     = st_q[k-1].rem_y - t;
          st_d[k].quo_y[Sh] = 1'b1;
        end
      end
    end

    assign rdy[k] = !v_q[k] || rdy[k+1];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (rdy[k]) begin
        v_q[k] <= (k == 0) ? valid_i : v_q[(k == 0) ? 0 : k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[k]) st_q[k] <= st_d[k];
    end
  end

  assign ready_o = rdy[0];
  assign valid_o = v_q[QBits];
  assign mag_x_o = st_q[QBits].ov_x ? '1 : st_q[QBits].quo_x;
  assign mag_y_o = st_q[QBits].ov_y ? '1 : st_q[QBits].quo_y;
  assign neg_x_o = st_q[QBits].neg_x;
  assign neg_y_o = st_q[QBits].neg_y;
  assign side_o  = st_q[QBits].side;

endmodule

/* hdl/sid_judge.sv */
// ----------------------------------------------------------------------------
// sid_judge: box tests, saturation and the output register
// Applies the quotient signs, tests both boxes or the containment rule for
// coincident lines, and holds the finished result for the receiver.
// ----------------------------------------------------------------------------
module sid_judge import sid_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  logic [QBits-1:0] mag_x_i,
  input  logic [QBits-1:0] mag_y_i,
  input  logic             neg_x_i,
  input  logic             neg_y_i,
  input  side_t            side_i,
  output logic             valid_o,
  input  logic             ready_i,
  output logic             hit_o,
  output logic             point_valid_o,
  output coef_t            point_x_o,
  output coef_t            point_y_o
);

  localparam logic signed [QW-1:0] QMax = QW'(coef_t'({1'b0, {(CoefW-1){1'b1}}}));
  localparam logic signed [QW-1:0] QMin = QW'(coef_t'({1'b1, {(CoefW-1){1'b0}}}));

  logic  v_q, hit_q, pv_q, hit_d, pv_d;
  coef_t px_q, py_q, px_d, py_d;

  function automatic logic signed [QW-1:0] lane_q(input box_t b, input int j);
    return QW'(box_lane(b, j));
  endfunction

  function automatic coef_t sat(input logic signed [QW-1:0] v);
    if (v > QMax) return coef_t'(QMax);
    if (v < QMin) return coef_t'(QMin);
    return coef_t'(v);
  endfunction

  function automatic logic in_box(input box_t b, input logic signed [QW-1:0] x,
                                  input logic signed [QW-1:0] y);
    return x >= lane_q(b, LaneXMin) && x <= lane_q(b, LaneXMax) &&
           y >= lane_q(b, LaneYMin) && y <= lane_q(b, LaneYMax);
  endfunction

  always_comb begin
    logic signed [QW-1:0] x, y;
    logic q_in_p, p_in_q;
    x = neg_x_i ? -$signed({1'b0, mag_x_i}) : $signed({1'b0, mag_x_i});
    y = neg_y_i ? -$signed({1'b0, mag_y_i}) : $signed({1'b0, mag_y_i});
    q_in_p = box_lane(side_i.p, LaneXMin) <= box_lane(side_i.q, LaneXMin) &&
             box_lane(side_i.p, LaneXMax) >= box_lane(side_i.q, LaneXMax) &&
             box_lane(side_i.p, LaneYMin) <= box_lane(side_i.q, LaneYMin) &&
             box_lane(side_i.p, LaneYMax) >= box_lane(side_i.q, LaneYMax);
    p_in_q = box_lane(side_i.p, LaneXMin) >  box_lane(side_i.q, LaneXMin) &&
             box_lane(side_i.p, LaneXMax) <  box_lane(side_i.q, LaneXMax) &&
             box_lane(side_i.p, LaneYMin) >  box_lane(side_i.q, LaneYMin) &&
             box_lane(side_i.p, LaneYMax) <  box_lane(side_i.q, LaneYMax);
    if (side_i.det_zero) begin
      pv_d  = 1'b0;
      px_d  = '0;
      py_d  = '0;
      hit_d = side_i.nx_zero && (q_in_p || p_in_q);
    end else begin
      pv_d  = 1'b1;
      px_d  = sat(x);
      py_d  = sat(y);
      hit_d = in_box(side_i.p, x, y) && in_box(side_i.q, x, y);
    end
  end

  assign ready_o = !v_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (ready_o) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o) begin
      hit_q <= hit_d;
      pv_q  <= pv_d;
      px_q  <= px_d;
      py_q  <= py_d;
    end
  end

  assign valid_o       = v_q;
  assign hit_o         = hit_q;
  assign point_valid_o = pv_q;
  assign point_x_o     = px_q;
  assign point_y_o     = py_q;

endmodule

/* hdl/segment_intersection_2d.sv */
// ----------------------------------------------------------------------------
// segment_intersection_2d: streaming 2D segment intersection test
// Solves two lines by Cramer's rule and checks the point against both boxes.
// ----------------------------------------------------------------------------
// Usage. Each input beat on the in_valid_i / in_ready_o channel carries two
// lines a*x + b*y + c = 0 in signed Q8.8 and their packed bounding boxes.
// Each beat yields exactly one output beat on out_valid_o / out_ready_i with
// hit, point_valid and the saturated Q8.8 intersection point.
//
// From acceptance to out_valid_o an item passes the product and determinant
// registers, the divider front end, the quotient stages (one bit per stage for
// x and y in parallel) and the box tests into the output register. Throughput
// is one beat per cycle while out_ready_i does not stall the pipeline; the
// quotient pipeline sets the depth, not the rate.
//
// Every stage has its own valid bit and takes new data when it is empty or
// its successor moves, so a stalled receiver only stops the stages that are
// full and bubbles are squeezed out. in_ready_o drops only once the whole
// pipeline holds items. Reset clears all valid bits; no result is pending
// after reset and the datapath registers are not reset.
// ----------------------------------------------------------------------------
module segment_intersection_2d import sid_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  coef_t first_a_i,
  input  coef_t first_b_i,
  input  coef_t first_c_i,
  input  coef_t second_a_i,
  input  coef_t second_b_i,
  input  coef_t second_c_i,
  input  box_t  first_box_i,
  input  box_t  second_box_i,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  output logic  hit_o,
  output logic  point_valid_o,
  output coef_t point_x_o,
  output coef_t point_y_o
);

  // Cross-product stage outputs.
  logic                   cr_valid, cr_ready;
  logic signed [SumW-1:0] cr_det, cr_nx, cr_ny;
  side_t                  cr_side;

  // Divider outputs.
  logic                   dv_valid, dv_ready;
  logic [QBits-1:0]       dv_mag_x, dv_mag_y;
  logic                   dv_neg_x, dv_neg_y;
  side_t                  dv_side;

  sid_cross u_cross (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (in_ready_o),
    .a1_i    (first_a_i),
    .b1_i    (first_b_i),
    .c1_i    (first_c_i),
    .a2_i    (second_a_i),
    .b2_i    (second_b_i),
    .c2_i    (second_c_i),
    .p_i     (first_box_i),
    .q_i     (second_box_i),
    .valid_o (cr_valid),
    .ready_i (cr_ready),
    .det_o   (cr_det),
    .nx_o    (cr_nx),
    .ny_o    (cr_ny),
    .side_o  (cr_side)
  );

  // The determinant is shared by both quotients, so x and y run side by side.
  sid_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (cr_valid),
    .ready_o (cr_ready),
    .det_i   (cr_det),
    .nx_i    (cr_nx),
    .ny_i    (cr_ny),
    .side_i  (cr_side),
    .valid_o (dv_valid),
    .ready_i (dv_ready),
    .mag_x_o (dv_mag_x),
    .mag_y_o (dv_mag_y),
    .neg_x_o (dv_neg_x),
    .neg_y_o (dv_neg_y),
    .side_o  (dv_side)
  );

  sid_judge u_judge (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (dv_valid),
    .ready_o       (dv_ready),
    .mag_x_i       (dv_mag_x),
    .mag_y_i       (dv_mag_y),
    .neg_x_i       (dv_neg_x),
    .neg_y_i       (dv_neg_y),
    .side_i        (dv_side),
    .valid_o       (out_valid_o),
    .ready_i       (out_ready_i),
    .hit_o         (hit_o),
    .point_valid_o (point_valid_o),
    .point_x_o     (point_x_o),
    .point_y_o     (point_y_o)
  );

  // Without a solved point both coordinates must read as zero.
  a_no_point_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !point_valid_o |-> point_x_o == '0 && point_y_o == '0)
    else $error("coordinates nonzero without a solved point");

  // The input side can only stall when the output register is occupied.
  a_stall_needs_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled while the output register is empty");

  // A draining output lets the whole chain move.
  a_drain_opens_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i |-> in_ready_o)
    else $error("input blocked while the output drains");

endmodule

/* tb/sv/segment_intersection_2d_checker.sv */
// ----------------------------------------------------------------------------
// segment_intersection_2d_checker: result predictor and scoreboard
// Watches both channels, solves each accepted beat by Cramer's rule and
// compares every output beat with the oldest pending answer.
// ----------------------------------------------------------------------------
module segment_intersection_2d_checker import sid_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  input  logic  in_ready_i,
  input  coef_t first_a_i,
  input  coef_t first_b_i,
  input  coef_t first_c_i,
  input  coef_t second_a_i,
  input  coef_t second_b_i,
  input  coef_t second_c_i,
  input  box_t  first_box_i,
  input  box_t  second_box_i,
  input  logic  out_valid_i,
  input  logic  out_ready_i,
  input  logic  hit_i,
  input  logic  point_valid_i,
  input  coef_t point_x_i,
  input  coef_t point_y_i,
  output int    fail_count_o,
  output int    pending_o
);

  typedef struct packed {
    logic  hit;
    logic  point_valid;
    coef_t x;
    coef_t y;
  } answer_t;

  answer_t answers_q[$];

  function automatic longint lane(input box_t b, input int j);
    return longint'(signed'(b[j*CoefW +: CoefW]));
  endfunction

  function automatic coef_t clamp_q(input longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return coef_t'(v);
  endfunction

  function automatic answer_t solve_segments(
      input coef_t a1, input coef_t b1, input coef_t c1,
      input coef_t a2, input coef_t b2, input coef_t c2,
      input box_t p, input box_t q);
    longint det, nx, ny, x, y;
    answer_t r;
    det = longint'(a1) * b2 - longint'(a2) * b1;
    nx  = longint'(b1) * c2 - longint'(b2) * c1;
    ny  = longint'(a2) * c1 - longint'(a1) * c2;
    r = '0;
    if (det == 0) begin
      // Coincident (or vertical-parallel) lines fall back to box containment.
      if (nx == 0) begin
        r.hit = (lane(p, LaneXMin) <= lane(q, LaneXMin) &&
                 lane(p, LaneXMax) >= lane(q, LaneXMax) &&
                 lane(p, LaneYMin) <= lane(q, LaneYMin) &&
                 lane(p, LaneYMax) >= lane(q, LaneYMax)) ||
                (lane(p, LaneXMin) > lane(q, LaneXMin) &&
                 lane(p, LaneXMax) < lane(q, LaneXMax) &&
                 lane(p, LaneYMin) > lane(q, LaneYMin) &&
                 lane(p, LaneYMax) < lane(q, LaneYMax));
      end
    end else begin
      x = (nx * 256) / det;
      y = (ny * 256) / det;
      r.point_valid = 1'b1;
      r.hit = x >= lane(p, LaneXMin) && x <= lane(p, LaneXMax) &&
              y >= lane(p, LaneYMin) && y <= lane(p, LaneYMax) &&
              x >= lane(q, LaneXMin) && x <= lane(q, LaneXMax) &&
              y >= lane(q, LaneYMin) && y <= lane(q, LaneYMax);
      r.x = clamp_q(x);
      r.y = clamp_q(y);
    end
    return r;
  endfunction

  assign pending_o = answers_q.size();

  always @(posedge clk_i) begin
    answer_t want;
    if (rst_ni && in_valid_i && in_ready_i)
      answers_q.push_back(solve_segments(first_a_i, first_b_i, first_c_i,
                                         second_a_i, second_b_i, second_c_i,
                                         first_box_i, second_box_i));
    if (rst_ni && out_valid_i && out_ready_i) begin
      if (answers_q.size() == 0) begin
        $error("output beat with no pending answer");
        fail_count_o <= fail_count_o + 1;
      end else begin
        want = answers_q.pop_front();
        if (want.hit !== hit_i || want.point_valid !== point_valid_i ||
            want.x !== point_x_i || want.y !== point_y_i) begin
          if (want.hit !== hit_i)
            $error("hit: expected %0d, got %0d", want.hit, hit_i);
          if (want.point_valid !== point_valid_i)
            $error("point_valid: expected %0d, got %0d", want.point_valid,
                   point_valid_i);
          if (want.x !== point_x_i)
            $error("point_x: expected %0d, got %0d", want.x, point_x_i);
          if (want.y !== point_y_i)
            $error("point_y: expected %0d, got %0d", want.y, point_y_i);
          fail_count_o <= fail_count_o + 1;
        end
      end
    end
  end

endmodule

/* tb/sv/segment_intersection_2d_tb.sv */
// ----------------------------------------------------------------------------
// segment_intersection_2d_tb: stimulus and verdict for the intersection block
// Drives directed and random line pairs with random gaps and output stalls;
// the checker predicts and compares every result beat.
// ----------------------------------------------------------------------------
module segment_intersection_2d_tb import sid_pkg::*;;

  localparam int NumRandom = 1650;
  localparam int CycleLimit = 200000;

  logic  clk_i = 1'b0;
  logic  rst_ni = 1'b0;
  logic  in_valid_i = 1'b0;
  logic  in_ready_o;
  coef_t first_a_i = '0, first_b_i = '0, first_c_i = '0;
  coef_t second_a_i = '0, second_b_i = '0, second_c_i = '0;
  box_t  first_box_i = '0, second_box_i = '0;
  logic  out_valid_o;
  logic  out_ready_i = 1'b0;
  logic  hit_o, point_valid_o;
  coef_t point_x_o, point_y_o;
  int    fail_count, pending;
  int    cycle_count = 0;
  bit    stall_free = 1'b0;

  initial forever #1 clk_i = ~clk_i;

  segment_intersection_2d u_dut (.*);

  segment_intersection_2d_checker u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o),
    .first_a_i, .first_b_i, .first_c_i, .second_a_i, .second_b_i, .second_c_i,
    .first_box_i, .second_box_i, .out_valid_i(out_valid_o), .out_ready_i,
    .hit_i(hit_o), .point_valid_i(point_valid_o), .point_x_i(point_x_o),
    .point_y_i(point_y_o), .fail_count_o(fail_count), .pending_o(pending)
  );

  // Packs four lanes into a box word, x_min in the low bits.
  function automatic box_t make_box(input coef_t x0, input coef_t x1,
                                    input coef_t y0, input coef_t y1);
    return {y1, y0, x1, x0};
  endfunction

  function automatic coef_t rnd_coef();
    case ($urandom_range(0, 5))
      0: return coef_t'($urandom_range(0, 1) ? 16'sh7fff : 16'sh8000);
      1: return coef_t'($urandom_range(0, 1) ? 0 : 256);
      2, 3: return coef_t'(int'($urandom_range(0, 2048)) - 1024);
      default: return coef_t'($urandom);
    endcase
  endfunction

  // A box around a center, sometimes inverted, sometimes huge.
  function automatic box_t rnd_box();
    int cx, cy, w, h;
    cx = int'($urandom_range(0, 4096)) - 2048;
    cy = int'($urandom_range(0, 4096)) - 2048;
    w = $urandom_range(0, 3000);
    h = $urandom_range(0, 3000);
    case ($urandom_range(0, 9))
      0: return box_t'({$urandom, $urandom});
      1: return make_box(16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff);
      2: return make_box(coef_t'(cx + w), coef_t'(cx - w), coef_t'(cy), coef_t'(cy + h));
      default: return make_box(coef_t'(cx - w), coef_t'(cx + w),
                               coef_t'(cy - h), coef_t'(cy + h));
    endcase
  endfunction

  // Waits a random gap with valid low, then presents one beat and holds it
  // until accepted. Valid stays high into the next beat when it has no gap.
  task automatic send_beat(input coef_t a1, input coef_t b1, input coef_t c1,
                           input coef_t a2, input coef_t b2, input coef_t c2,
                           input box_t p, input box_t q);
    int gap;
    gap = stall_free ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    first_a_i <= a1; first_b_i <= b1; first_c_i <= c1;
    second_a_i <= a2; second_b_i <= b2; second_c_i <= c2;
    first_box_i <= p; second_box_i <= q;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Random receiver stalls, drawn afresh after each accepted output beat.
  initial begin
    int wait_cycles;
    @(posedge rst_ni);
    forever begin
      wait_cycles = stall_free ? 0 : $urandom_range(0, 10);
      if (wait_cycles > 0) begin
        out_ready_i <= 1'b0;
        repeat (wait_cycles) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  initial begin
    @(posedge clk_i);
    cycle_count <= cycle_count + 1;
    forever begin
      @(posedge clk_i);
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    coef_t a1, b1, c1, a2, b2, c2, k;
    box_t p, q;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: crossing lines x=1 and y=1 inside a box from 0 to 2.
    p = make_box(0, 512, 0, 512);
    send_beat(256, 0, -256, 0, 256, -256, p, p);
    // Point exactly on the box bounds.
    send_beat(256, 0, 0, 0, 256, 0, make_box(0, 0, 0, 0), make_box(0, 0, 0, 0));
    // Parallel lines: same normal, different offset.
    send_beat(256, 256, 0, 256, 256, 256, p, p);
    // Coincident lines, second box inside the first (inclusive).
    send_beat(256, 256, 0, 512, 512, 0, p, make_box(0, 256, 0, 512));
    // Coincident, first strictly inside the second.
    send_beat(256, 256, 0, 256, 256, 0, make_box(1, 2, 1, 2), p);
    // Coincident, first not strictly inside (shares a bound).
    send_beat(256, 256, 0, 256, 256, 0, make_box(0, 2, 1, 2), p);
    // Two distinct vertical lines land in the coincident case.
    send_beat(256, 0, 0, 256, 0, -256, p, make_box(1, 2, 1, 2));
    // All-zero coefficients.
    send_beat(0, 0, 0, 0, 0, 0, '0, '0);
    // Extremes: saturation in both directions and full-range values.
    send_beat(1, 0, 16'sh8000, 0, 1, 16'sh7fff, '1, '0);
    send_beat(16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff,
              make_box(16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff), '1);
    send_beat(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000,
              {4{16'sh7fff}}, {4{16'sh8000}});
    send_beat(-1, 1, -1, 1, 1, 1, make_box(-512, 512, -512, 512),
              make_box(-512, 512, -512, 512));
    // Inverted box on an otherwise good crossing.
    send_beat(256, 0, -256, 0, 256, -256, make_box(512, 0, 0, 512), p);
    // Negative quotient truncated toward zero.
    send_beat(3, 0, 1, 0, 3, -1, '1, make_box(-300, 300, -300, 300));

    for (int i = 0; i < NumRandom; i++) begin
      // Alternate stretches with and without gaps.
      if (i % 200 == 0) stall_free = (i % 400 == 200);
      p = rnd_box();
      q = rnd_box();
      a1 = rnd_coef(); b1 = rnd_coef(); c1 = rnd_coef();
      case ($urandom_range(0, 9))
        0: begin
          // Scaled copy of the first line: coincident case.
          k = coef_t'($urandom_range(1, 3));
          a2 = a1 * k; b2 = b1 * k; c2 = c1 * k;
          if ($urandom_range(0, 1)) q = p;
        end
        1: begin
          a2 = a1; b2 = b1; c2 = rnd_coef();
        end
        default: begin
          a2 = rnd_coef(); b2 = rnd_coef(); c2 = rnd_coef();
        end
      endcase
      send_beat(a1, b1, c1, a2, b2, c2, p, q);
    end
    in_valid_i <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
